@@ rtl/cdq_pkg.sv @@
package cdq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W = 32;
  localparam int CAP_W = 7;
  localparam int OP_W = 3;
  localparam logic [VAL_W-1:0] EMPTY_VAL = {VAL_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_QUERY     = 3'd4
  } cdq_op_t;

  typedef struct packed {
    logic             shr;
    logic             shl;
    logic             wr;
    logic [VAL_W-1:0] value;
  } cdq_ctl_t;

endpackage

@@ rtl/cdq_cell.sv @@
module cdq_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  cdq_pkg::cdq_ctl_t       ctl,
  input  logic [CW-1:0]           cnt,
  input  logic [cdq_pkg::VAL_W-1:0] left_in,
  input  logic [cdq_pkg::VAL_W-1:0] right_in,
  output logic [cdq_pkg::VAL_W-1:0] data_q,
  output logic [cdq_pkg::VAL_W-1:0] data_d
);
  import cdq_pkg::*;

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shr) begin
      data_nxt = left_in;
    end else if (ctl.shl) begin
      data_nxt = right_in;
    end else if (ctl.wr && (cnt == CW'(IDX))) begin
      data_nxt = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign data_d = data_nxt;

endmodule

@@ rtl/cdq_chain.sv @@
module cdq_chain #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int CW    = 7
) (
  input  logic                      clk,
  input  cdq_pkg::cdq_ctl_t         ctl,
  input  logic [CW-1:0]             cnt,
  output logic [cdq_pkg::VAL_W-1:0] head_nxt
);
  import cdq_pkg::*;

  logic [VAL_W-1:0] q [DEPTH];
  logic [VAL_W-1:0] d [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = ctl.value;
    end else begin : g_mid_l
      assign left_val = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = q[i];
    end else begin : g_mid_r
      assign right_val = q[i+1];
    end

    cdq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cnt      (cnt),
      .left_in  (left_val),
      .right_in (right_val),
      .data_q   (q[i]),
      .data_d   (d[i])
    );
  end

  assign head_nxt = d[0];

endmodule

@@ rtl/circular_deque_top.sv @@
// Latency: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the result side does not stall; every cell
// of both shift chains updates in the same cycle, so no operation takes longer.
// Reset clears the entry count and the result valid and sets the capacity to DEPTH.
// The stored values are not cleared; they are never shown before being written.
module circular_deque_top #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cdq_pkg::OP_W-1:0]        in_op,
  input  logic signed [cdq_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic signed [cdq_pkg::VAL_W-1:0] out_front_value,
  output logic signed [cdq_pkg::VAL_W-1:0] out_rear_value,
  output logic                            out_is_empty,
  output logic                            out_is_full,
  output logic [cdq_pkg::CAP_W-1:0]       out_entry_count,
  input  logic                            cfg_wr_en,
  input  logic [cdq_pkg::CAP_W-1:0]       cfg_wr_data
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [CAPW-1:0]  cap_r;
  logic [CAPW-1:0]  cap_wr;
  logic [CAPW-1:0]  cnt_ext;
  logic             accept;
  logic             full;
  logic             empty;
  logic             ok;
  logic             ins_ok;
  logic             del_ok;
  cdq_op_t          op;
  cdq_ctl_t         ctl_front;
  cdq_ctl_t         ctl_rear;
  logic [VAL_W-1:0] front_nxt;
  logic [VAL_W-1:0] rear_nxt;

  logic             out_valid_r;
  logic             out_ok_r;
  logic [VAL_W-1:0] out_front_r;
  logic [VAL_W-1:0] out_rear_r;
  logic             out_empty_r;
  logic             out_full_r;
  logic [CAP_W-1:0] out_count_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept = in_valid & ~in_stall;
  assign op = cdq_op_t'(in_op);
  assign full = (CAPW'(cnt_r) >= cap_r);
  assign empty = (cnt_r == '0);

  always_comb begin
    ok = 1'b0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    ctl_front = '0;
    ctl_rear = '0;
    ctl_front.value = in_value;
    ctl_rear.value = in_value;
    unique case (op)
      OP_INS_FRONT: begin
        if (!full) begin
          ok = 1'b1;
          ins_ok = 1'b1;
          ctl_front.shr = accept;
          ctl_rear.wr = accept;
        end
      end
      OP_INS_REAR: begin
        if (!full) begin
          ok = 1'b1;
          ins_ok = 1'b1;
          ctl_rear.shr = accept;
          ctl_front.wr = accept;
        end
      end
      OP_DEL_FRONT: begin
        if (!empty) begin
          ok = 1'b1;
          del_ok = 1'b1;
          ctl_front.shl = accept;
        end
      end
      OP_DEL_REAR: begin
        if (!empty) begin
          ok = 1'b1;
          del_ok = 1'b1;
          ctl_rear.shl = accept;
        end
      end
      OP_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && ins_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (accept && del_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  assign cnt_ext = CAPW'(cnt_nxt);

  always_comb begin
    cap_wr = CAPW'(cfg_wr_data);
    if (cap_wr == '0) begin
      cap_wr = CAPW'(1);
    end else if (cap_wr > CAPW'(DEPTH)) begin
      cap_wr = CAPW'(DEPTH);
    end
  end

  cdq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_front_chain (
    .clk      (clk),
    .ctl      (ctl_front),
    .cnt      (cnt_r),
    .head_nxt (front_nxt)
  );

  cdq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_rear_chain (
    .clk      (clk),
    .ctl      (ctl_rear),
    .cnt      (cnt_r),
    .head_nxt (rear_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= CAPW'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_wr_en && empty) begin
        cap_r <= cap_wr;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r <= ok;
      out_front_r <= (cnt_nxt == '0) ? EMPTY_VAL : front_nxt;
      out_rear_r <= (cnt_nxt == '0) ? EMPTY_VAL : rear_nxt;
      out_empty_r <= (cnt_nxt == '0);
      out_full_r <= (cnt_ext >= cap_r);
      out_count_r <= cnt_ext[CAP_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok = out_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value = out_rear_r;
  assign out_is_empty = out_empty_r;
  assign out_is_full = out_full_r;
  assign out_entry_count = out_count_r;

  a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CAPW'(cnt_r) <= cap_r)
    else $error("entry count exceeds capacity");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= CAPW'(DEPTH)))
    else $error("capacity out of range");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ins_ok) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("successful insert did not raise the count");

  a_delete_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && del_ok) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("successful delete did not lower the count");

endmodule

@@ tb/tb_circular_deque_top.sv @@
`timescale 1ns / 100ps

module tb_circular_deque_top;
  import cdq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [VAL_W-1:0] VAL_NONE = EMPTY_VAL;
  localparam logic signed [VAL_W-1:0] VAL_PAT = 32'sh5A5A5A5A;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] front;
    logic signed [VAL_W-1:0] rear;
    logic                    empty;
    logic                    full;
    logic [CAP_W-1:0]        count;
  } deque_status_t;

  typedef enum logic {ROW_BEAT, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    deque_status_t           status;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op = OP_QUERY;
  logic signed [VAL_W-1:0]  in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_ok;
  logic signed [VAL_W-1:0]  out_front_value;
  logic signed [VAL_W-1:0]  out_rear_value;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic [CAP_W-1:0]         out_entry_count;
  logic                     cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]         cfg_wr_data = '0;

  logic signed [VAL_W-1:0]  held_vals[$];
  int unsigned              held_cap = DEPTH;
  deque_status_t            status_q[$];
  deque_status_t            want;
  plan_row_t                plan_q[$];
  int                       idle_mode = 0;
  int                       err_cnt = 0;

  circular_deque_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_idle_pct();
    return (idle_mode == 1) ? 68 : (idle_mode == 3) ? 22 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == 2) ? 68 : (idle_mode == 3) ? 22 : 0;
  endfunction

  function automatic deque_status_t apply_op(input logic [OP_W-1:0] op,
                                             input logic signed [VAL_W-1:0] val);
    deque_status_t s;
    logic          was_full;
    logic          was_empty;
    was_full = (held_vals.size() >= held_cap);
    was_empty = (held_vals.size() == 0);
    s.ok = 1'b0;
    case (op)
      OP_INS_FRONT: if (!was_full) begin
        held_vals.push_front(val);
        s.ok = 1'b1;
      end
      OP_INS_REAR: if (!was_full) begin
        held_vals.push_back(val);
        s.ok = 1'b1;
      end
      OP_DEL_FRONT: if (!was_empty) begin
        void'(held_vals.pop_front());
        s.ok = 1'b1;
      end
      OP_DEL_REAR: if (!was_empty) begin
        void'(held_vals.pop_back());
        s.ok = 1'b1;
      end
      OP_QUERY: s.ok = 1'b1;
      default: s.ok = 1'b0;
    endcase
    s.empty = (held_vals.size() == 0);
    s.full = (held_vals.size() >= held_cap);
    s.count = CAP_W'(held_vals.size());
    s.front = s.empty ? VAL_NONE : held_vals[0];
    s.rear = s.empty ? VAL_NONE : held_vals[held_vals.size() - 1];
    return s;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int ins_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
    if (r < 10) return OP_QUERY;
    if ($urandom_range(0, 99) < ins_bias) return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
    return $urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR;
  endfunction

  // The valid stays high after a beat so that a following beat needs no second
  // assignment in the same step; callers that stop sending go through wait_idle.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                           input logic typed, input deque_status_t typed_status);
    deque_status_t pred;
    while (roll(send_idle_pct())) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    pred = apply_op(op, val);
    status_q.push_back(typed ? typed_status : pred);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (held_vals.size() == 0) begin
      held_cap = (cap == 0) ? 1 : (cap > DEPTH) ? DEPTH : cap;
    end
  endtask

  task automatic add_row(input row_kind_t kind, input logic [OP_W-1:0] op,
                         input logic signed [VAL_W-1:0] val, input logic typed,
                         input deque_status_t status);
    plan_q.push_back('{kind, op, val, typed, status});
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $error("result beat arrived with nothing expected");
        err_cnt++;
      end else begin
        want = status_q.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          err_cnt++;
        end
        if (out_front_value !== want.front) begin
          $error("front_value: expected %0d, got %0d", want.front, out_front_value);
          err_cnt++;
        end
        if (out_rear_value !== want.rear) begin
          $error("rear_value: expected %0d, got %0d", want.rear, out_rear_value);
          err_cnt++;
        end
        if (out_is_empty !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, out_is_empty);
          err_cnt++;
        end
        if (out_is_full !== want.full) begin
          $error("is_full: expected %0d, got %0d", want.full, out_is_full);
          err_cnt++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          err_cnt++;
        end
      end
    end
    out_stall <= roll(recv_stall_pct());
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int            cap_plan[8];
    int            ins_bias;
    deque_status_t none;
    none = '0;

    add_row(ROW_BEAT, OP_QUERY, 0, 1'b1, '{1'b1, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 7'd0});
    add_row(ROW_BEAT, OP_DEL_FRONT, 0, 1'b1, '{1'b0, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 7'd0});
    add_row(ROW_BEAT, OP_DEL_REAR, 0, 1'b1, '{1'b0, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 7'd0});
    add_row(ROW_BEAT, OP_RSVD_A, 0, 1'b1, '{1'b0, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 7'd0});
    add_row(ROW_BEAT, OP_INS_REAR, VAL_MAX, 1'b1, '{1'b1, VAL_MAX, VAL_MAX, 1'b0, 1'b0, 7'd1});
    add_row(ROW_BEAT, OP_INS_FRONT, VAL_MIN, 1'b1, '{1'b1, VAL_MIN, VAL_MAX, 1'b0, 1'b0, 7'd2});
    add_row(ROW_BEAT, OP_INS_REAR, VAL_NONE, 1'b1, '{1'b1, VAL_MIN, VAL_NONE, 1'b0, 1'b0, 7'd3});
    add_row(ROW_BEAT, OP_INS_FRONT, 0, 1'b1, '{1'b1, 32'sd0, VAL_NONE, 1'b0, 1'b0, 7'd4});
    add_row(ROW_BEAT, OP_RSVD_C, VAL_PAT, 1'b0, none);
    add_row(ROW_BEAT, OP_QUERY, VAL_MAX, 1'b0, none);
    add_row(ROW_BEAT, OP_DEL_FRONT, 0, 1'b0, none);
    add_row(ROW_BEAT, OP_DEL_REAR, 0, 1'b0, none);
    add_row(ROW_BEAT, OP_DEL_REAR, 0, 1'b0, none);
    add_row(ROW_BEAT, OP_DEL_FRONT, 0, 1'b1, '{1'b1, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 7'd0});
    add_row(ROW_CAP, OP_QUERY, 0, 1'b0, none);
    add_row(ROW_BEAT, OP_INS_REAR, VAL_PAT, 1'b1, '{1'b1, VAL_PAT, VAL_PAT, 1'b0, 1'b1, 7'd1});
    add_row(ROW_BEAT, OP_INS_FRONT, 1, 1'b1, '{1'b0, VAL_PAT, VAL_PAT, 1'b0, 1'b1, 7'd1});
    add_row(ROW_BEAT, OP_INS_REAR, 2, 1'b1, '{1'b0, VAL_PAT, VAL_PAT, 1'b0, 1'b1, 7'd1});
    add_row(ROW_CAP, OP_QUERY, 64, 1'b0, none);
    add_row(ROW_BEAT, OP_QUERY, 0, 1'b1, '{1'b1, VAL_PAT, VAL_PAT, 1'b0, 1'b1, 7'd1});
    add_row(ROW_BEAT, OP_DEL_FRONT, 0, 1'b1, '{1'b1, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 7'd0});
    add_row(ROW_CAP, OP_QUERY, 127, 1'b0, none);
    add_row(ROW_BEAT, OP_RSVD_B, VAL_MIN, 1'b0, none);
    add_row(ROW_BEAT, OP_INS_FRONT, 32'sh0F0F0F0F, 1'b0, none);
    add_row(ROW_BEAT, OP_DEL_REAR, 0, 1'b0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_mode = 3;
    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CAP) begin
        wait_idle();
        write_capacity(CAP_W'(plan_q[i].value));
      end else begin
        send_beat(plan_q[i].op, plan_q[i].value, plan_q[i].typed, plan_q[i].status);
      end
    end

    cap_plan = '{64, 1, 2, 0, 127, 65, 33, 1};
    cap_plan[7] = $urandom_range(1, DEPTH);
    ins_bias = 50;
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      if ($urandom_range(0, 2) != 0) begin
        while (held_vals.size() != 0) begin
          send_beat($urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR, 32'($urandom), 1'b0, none);
        end
      end
      wait_idle();
      write_capacity(CAP_W'(cap_plan[ph]));
      for (int n = 0; n < 190; n++) begin
        if (n % 40 == 0) ins_bias = $urandom_range(0, 1) ? 75 : 25;
        send_beat(pick_op(ins_bias), 32'($urandom), 1'b0, none);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/cdq_chain.sv
rtl/circular_deque_top.sv
tb/tb_circular_deque_top.sv
